// ===== hw/rtl/wrdr_pkg.sv =====
// ----------------------------------------------------------------------------
// wrdr_pkg
// Types, constants and small calendar functions shared by the weekday rule
// day resolver pipeline.
// ----------------------------------------------------------------------------
package wrdr_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int WDAY_W  = 3;
	localparam int OP_W    = 2;

	// shifted Julian year: year + 4800 fits 15 bits
	localparam int YY_W    = 15;
	localparam int Q25_W   = 10;
	localparam int Q100_W  = 8;
	localparam int BASE_W  = 16;

	// floor(x / 25) = (x * 20972) >> 19 for x < 43690
	localparam logic [14:0] RECIP_25       = 15'd20972;
	localparam int          RECIP_25_SHIFT = 19;
	// floor(x / 100) = (x * 20972) >> 21 for x < 43690
	localparam logic [14:0] RECIP_100       = 15'd20972;
	localparam int          RECIP_100_SHIFT = 21;

	localparam logic [YY_W-1:0] JDN_YEAR_BIAS = 15'd4800;
	// 217 keeps the sum positive after subtracting year/100 (a multiple of 7),
	// plus 2 which is (1 - 32045) mod 7
	localparam logic [BASE_W-1:0] BASE_BIAS = 16'd219;

	typedef enum logic [OP_W-1:0] {
		OP_LAST   = 2'd0,
		OP_AFTER  = 2'd1,
		OP_BEFORE = 2'd2
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [WDAY_W-1:0]  weekday;
		logic [YY_W-1:0]    yy;
		logic [Q25_W-1:0]   q25;
		logic [Q100_W-1:0]  q100;
	} dec_t;

	typedef struct packed {
		op_t                op;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [WDAY_W-1:0]  weekday;
		logic [DAY_W-1:0]   dim;
		logic               leap;
		logic [2:0]         base7;
	} cal_t;

	// Length of a month 1..12.
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] d;
		case (m)
			4'd2:                     d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
			default:                  d = 5'd31;
		endcase
		return d;
	endfunction

	// ((153 * mm + 2) / 5) mod 7 for the March-based month index of month m.
	function automatic logic [2:0] month_offset7(input logic [MONTH_W-1:0] m);
		logic [2:0] r;
		case (m)
			4'd1:  r = 3'd5;
			4'd2:  r = 3'd1;
			4'd3:  r = 3'd0;
			4'd4:  r = 3'd3;
			4'd5:  r = 3'd5;
			4'd6:  r = 3'd1;
			4'd7:  r = 3'd3;
			4'd8:  r = 3'd6;
			4'd9:  r = 3'd2;
			4'd10: r = 3'd4;
			4'd11: r = 3'd0;
			default: r = 3'd2;
		endcase
		return r;
	endfunction

	// x mod 7 by folding octal digits (8 is 1 mod 7).
	function automatic logic [2:0] mod7(input logic [BASE_W-1:0] x);
		logic [17:0] xe;
		logic [5:0]  f1;
		logic [3:0]  f2;
		logic [2:0]  f3;
		xe = {2'b00, x};
		f1 = 6'(xe[2:0]) + 6'(xe[5:3]) + 6'(xe[8:6]) + 6'(xe[11:9])
			+ 6'(xe[14:12]) + 6'(xe[17:15]);
		f2 = 4'(f1[5:3]) + 4'(f1[2:0]);
		f3 = 3'(f2[3]) + f2[2:0];
		return (f3 == 3'd7) ? 3'd0 : f3;
	endfunction

endpackage

// ===== hw/rtl/wrdr_decode.sv =====
// ----------------------------------------------------------------------------
// wrdr_decode
// Stage 1: clamp the request fields and run the reciprocal multiplies for
// year/25 and shifted-year/100.
// ----------------------------------------------------------------------------
module wrdr_decode
	import wrdr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [OP_W-1:0]     op,
	input  logic [YEAR_W-1:0]   year,
	input  logic [MONTH_W-1:0]  month,
	input  logic [DAY_W-1:0]    day,
	input  logic [WDAY_W-1:0]   weekday,
	output logic                valid_s1,
	output dec_t                dec_s1
);

	dec_t        dec_c;
	logic        early;
	logic [28:0] prod25;
	logic [29:0] prod100;

	always_comb begin
		unique case (op)
			OP_AFTER:  dec_c.op = OP_AFTER;
			OP_BEFORE: dec_c.op = OP_BEFORE;
			default:   dec_c.op = OP_LAST;
		endcase
		dec_c.year = year;
		if (month == 4'd0) begin
			dec_c.month = 4'd1;
		end else if (month > 4'd12) begin
			dec_c.month = 4'd12;
		end else begin
			dec_c.month = month;
		end
		dec_c.day     = day;
		dec_c.weekday = (weekday == 3'd7) ? 3'd0 : weekday;
		early    = (dec_c.month <= 4'd2);
		dec_c.yy = YY_W'(year) + JDN_YEAR_BIAS - YY_W'(early);
		prod25   = 29'(year) * 29'(RECIP_25);
		prod100  = 30'(dec_c.yy) * 30'(RECIP_100);
		dec_c.q25  = prod25[RECIP_25_SHIFT +: Q25_W];
		dec_c.q100 = prod100[RECIP_100_SHIFT +: Q100_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s1 <= dec_c;
		end
	end

endmodule

// ===== hw/rtl/wrdr_calendar.sv =====
// ----------------------------------------------------------------------------
// wrdr_calendar
// Stage 2: leap year, month length, day clamp and the day-independent part
// of the weekday sum reduced mod 7.
// ----------------------------------------------------------------------------
module wrdr_calendar
	import wrdr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  valid_s1,
	input  dec_t  dec_s1,
	output logic  valid_s2,
	output cal_t  cal_s2
);

	cal_t              cal_c;
	logic [14:0]       mul25;
	logic              div25;
	logic [BASE_W-1:0] base;

	always_comb begin
		mul25 = (15'(dec_s1.q25) << 4) + (15'(dec_s1.q25) << 3) + 15'(dec_s1.q25);
		div25 = (mul25 == 15'(dec_s1.year));
		cal_c.op      = dec_s1.op;
		cal_c.year    = dec_s1.year;
		cal_c.month   = dec_s1.month;
		cal_c.weekday = dec_s1.weekday;
		cal_c.leap    = (dec_s1.year[1:0] == 2'b00)
			&& (!div25 || (dec_s1.year[3:0] == 4'd0));
		cal_c.dim = month_days(dec_s1.month, cal_c.leap);
		// last-weekday mode counts back from the month's last day
		if (dec_s1.op == OP_LAST) begin
			cal_c.day = cal_c.dim;
		end else if (dec_s1.day == 5'd0) begin
			cal_c.day = 5'd1;
		end else if (dec_s1.day > cal_c.dim) begin
			cal_c.day = cal_c.dim;
		end else begin
			cal_c.day = dec_s1.day;
		end
		base = BASE_W'(dec_s1.yy) + BASE_W'(dec_s1.yy[YY_W-1:2])
			+ BASE_W'(dec_s1.q100[Q100_W-1:2]) + BASE_W'(month_offset7(dec_s1.month))
			+ BASE_BIAS - BASE_W'(dec_s1.q100);
		cal_c.base7 = mod7(base);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cal_s2 <= cal_c;
		end
	end

endmodule

// ===== hw/rtl/wrdr_resolve.sv =====
// ----------------------------------------------------------------------------
// wrdr_resolve
// Stage 3: weekday of the reference day, distance to the target weekday and
// month/year rollover; holds the result register.
// ----------------------------------------------------------------------------
module wrdr_resolve
	import wrdr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_s2,
	input  cal_t                cal_s2,
	output logic                valid_s3,
	output logic [YEAR_W-1:0]   year_s3,
	output logic [MONTH_W-1:0]  month_s3,
	output logic [DAY_W-1:0]    day_s3
);

	logic [2:0]         cur;
	logic [2:0]         dist_fwd;
	logic [2:0]         dist_bwd;
	logic [5:0]         sum_fwd;
	logic [DAY_W-1:0]   prev_dim;
	logic [MONTH_W-1:0] prev_month;
	logic [YEAR_W-1:0]  prev_year;
	logic [YEAR_W-1:0]  year_c;
	logic [MONTH_W-1:0] month_c;
	logic [5:0]         day_c;

	always_comb begin
		cur = mod7(BASE_W'(cal_s2.base7) + BASE_W'(cal_s2.day));
		dist_fwd = (cal_s2.weekday >= cur) ? (cal_s2.weekday - cur)
			: (cal_s2.weekday + 3'd7 - cur);
		dist_bwd = (cur >= cal_s2.weekday) ? (cur - cal_s2.weekday)
			: (cur + 3'd7 - cal_s2.weekday);
		sum_fwd = 6'(cal_s2.day) + 6'(dist_fwd);
		// previous month stays in the same year unless January; a February
		// borrow only happens from March, so this year's leap flag applies
		if (cal_s2.month == 4'd1) begin
			prev_month = 4'd12;
			prev_year  = cal_s2.year - 14'd1;
		end else begin
			prev_month = cal_s2.month - 4'd1;
			prev_year  = cal_s2.year;
		end
		prev_dim = month_days(prev_month, cal_s2.leap);

		year_c  = cal_s2.year;
		month_c = cal_s2.month;
		unique case (cal_s2.op)
			OP_AFTER: begin
				day_c = sum_fwd;
				if (sum_fwd > 6'(cal_s2.dim)) begin
					day_c = sum_fwd - 6'(cal_s2.dim);
					if (cal_s2.month == 4'd12) begin
						month_c = 4'd1;
						year_c  = cal_s2.year + 14'd1;
					end else begin
						month_c = cal_s2.month + 4'd1;
					end
				end
			end
			OP_BEFORE: begin
				if (6'(cal_s2.day) <= 6'(dist_bwd)) begin
					month_c = prev_month;
					year_c  = prev_year;
					day_c   = 6'(cal_s2.day) + 6'(prev_dim) - 6'(dist_bwd);
				end else begin
					day_c = 6'(cal_s2.day) - 6'(dist_bwd);
				end
			end
			default: begin
				day_c = 6'(cal_s2.dim) - 6'(dist_bwd);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			year_s3  <= year_c;
			month_s3 <= month_c;
			day_s3   <= day_c[DAY_W-1:0];
		end
	end

endmodule

// ===== hw/rtl/weekday_rule_day_resolver.sv =====
// ----------------------------------------------------------------------------
// weekday_rule_day_resolver
// Resolves a daylight-saving style weekday rule (last / on-or-after /
// on-or-before a weekday) into a calendar date.
// ----------------------------------------------------------------------------
// One request in, one result out, in order. The block is a three-stage
// pipeline and takes a new request every cycle while in_stall is low. A
// request accepted into the stage 1 register moves through the stage 2
// register into the result register, and is taken from there when the
// output is not stalled.
// Stage 1 clamps the fields and runs the reciprocal multiplies that stand in
// for year/25 and year/100, stage 2 works out the leap year, the month length
// and the day-independent weekday sum mod 7, stage 3 finds the weekday
// distance and applies month and year rollover into the result register.
// Each stage advances when the stage after it is empty or advancing, so a
// stall on the result side fills bubbles first and reaches in_stall only
// when all three stages hold a request. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module weekday_rule_day_resolver
	import wrdr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     op,
	input  logic [YEAR_W-1:0]   year,
	input  logic [MONTH_W-1:0]  month,
	input  logic [DAY_W-1:0]    day,
	input  logic [WDAY_W-1:0]   weekday,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [YEAR_W-1:0]   result_year,
	output logic [MONTH_W-1:0]  result_month,
	output logic [DAY_W-1:0]    resolved_day
);

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	dec_t dec_s1;
	cal_t cal_s2;
	logic en1;
	logic en2;
	logic en3;

	// Advance a stage when its successor can take the request or it is empty.
	assign en3      = !out_stall || !valid_s3;
	assign en2      = en3 || !valid_s2;
	assign en1      = en2 || !valid_s1;
	assign in_stall = !en1;

	wrdr_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en1),
		.in_valid (in_valid),
		.op       (op),
		.year     (year),
		.month    (month),
		.day      (day),
		.weekday  (weekday),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1)
	);

	wrdr_calendar u_calendar (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1),
		.valid_s2 (valid_s2),
		.cal_s2   (cal_s2)
	);

	// Hold the finished result here while the consumer stalls.
	wrdr_resolve u_resolve (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en3),
		.valid_s2 (valid_s2),
		.cal_s2   (cal_s2),
		.valid_s3 (valid_s3),
		.year_s3  (result_year),
		.month_s3 (result_month),
		.day_s3   (resolved_day)
	);

	assign out_valid = valid_s3;

endmodule

// ===== hw/rtl/wrdr_checker.sv =====
// ----------------------------------------------------------------------------
// wrdr_checker
// Port-level checks for the weekday rule day resolver, bound to the top.
// ----------------------------------------------------------------------------
module wrdr_checker
	import wrdr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [YEAR_W-1:0]   result_year,
	input  logic [MONTH_W-1:0]  result_month,
	input  logic [DAY_W-1:0]    resolved_day
);

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_year)
			&& $stable(result_month) && $stable(resolved_day))
		else $error("stalled result changed");

	// back-pressure only ever comes from the output side
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output free");

	// an accepted request reaches out_valid while the output stays free
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("result missing after three cycles");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (result_month >= 4'd1) && (result_month <= 4'd12)
			&& (resolved_day != 5'd0))
		else $error("result date out of range");

endmodule

bind weekday_rule_day_resolver wrdr_checker u_wrdr_checker (.*);

// ===== test/weekday_rule_day_resolver_test.sv =====
// ----------------------------------------------------------------------------
// weekday_rule_day_resolver_test
// Self-checking bench for the weekday rule day resolver. A short table of
// directed requests (calendar edges, every mode, clamped and wrapped fields)
// is followed by random requests, mostly well-formed dates with some raw
// field noise. A behavioral calendar predictor computes every expected date
// not typed in, and each result is checked in order against the expected
// dates. Both sides idle at random, the result side holds off long enough
// to back the pipeline up, and the last part of the run streams with no gaps.
// ----------------------------------------------------------------------------
module weekday_rule_day_resolver_test;
	import wrdr_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_COUNT     = 480;
	localparam int STREAM_COUNT     = 80;
	localparam int LONG_HOLD_CYCLES = 64;
	localparam int DRAIN_CYCLES     = 8;
	localparam int CYCLE_LIMIT      = 120000;

	// One request, with an optional hand-written expected date.
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [WDAY_W-1:0]  weekday;
		logic               typed;
		logic [YEAR_W-1:0]  exp_year;
		logic [MONTH_W-1:0] exp_month;
		logic [DAY_W-1:0]   exp_day;
	} rule_row_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} rule_date_t;

	localparam int ROW_COUNT = 21;

	// Weekdays: 0 Sunday .. 6 Saturday. Expected dates are typed in only
	// where the calendar answer is plain; other rows go through the predictor.
	localparam rule_row_t RULE_ROWS [ROW_COUNT] = '{
		// last Sunday of March 2024
		'{OP_LAST,   14'd2024,  4'd3,  5'd1,  3'd0, 1'b1, 14'd2024,  4'd3,  5'd31},
		// Tuesday Dec 31 2024, next Wednesday is New Year's Day
		'{OP_AFTER,  14'd2024,  4'd12, 5'd31, 3'd3, 1'b1, 14'd2025,  4'd1,  5'd1},
		// Monday Jan 1 2024 back to Sunday of the previous year
		'{OP_BEFORE, 14'd2024,  4'd1,  5'd1,  3'd0, 1'b1, 14'd2023,  4'd12, 5'd31},
		// day already on the target weekday, both directions
		'{OP_AFTER,  14'd2024,  4'd3,  5'd31, 3'd0, 1'b1, 14'd2024,  4'd3,  5'd31},
		'{OP_BEFORE, 14'd2024,  4'd3,  5'd31, 3'd0, 1'b1, 14'd2024,  4'd3,  5'd31},
		// leap day forward into March
		'{OP_AFTER,  14'd2024,  4'd2,  5'd29, 3'd5, 1'b1, 14'd2024,  4'd3,  5'd1},
		// borrow from leap February: Friday Mar 1 back to Saturday
		'{OP_BEFORE, 14'd2024,  4'd3,  5'd1,  3'd6, 1'b1, 14'd2024,  4'd2,  5'd24},
		// top year rolls forward and wraps to year zero
		'{OP_AFTER,  14'd16383, 4'd12, 5'd31, 3'd0, 1'b1, 14'd0,     4'd1,  5'd1},
		// year zero rolls back and wraps to the top year
		'{OP_BEFORE, 14'd0,     4'd1,  5'd1,  3'd5, 1'b1, 14'd16383, 4'd12, 5'd31},
		// unused op code behaves as last-of-month
		'{OP_UNUSED, 14'd2024,  4'd3,  5'd5,  3'd0, 1'b1, 14'd2024,  4'd3,  5'd31},
		// month zero and day zero clamp to Jan 1
		'{OP_AFTER,  14'd2024,  4'd0,  5'd0,  3'd0, 1'b1, 14'd2024,  4'd1,  5'd7},
		// month fifteen clamps to December, weekday seven reads as Sunday
		'{OP_BEFORE, 14'd2023,  4'd15, 5'd31, 3'd7, 1'b1, 14'd2023,  4'd12, 5'd31},
		// day past a short February clamps to the 28th, then rolls forward
		'{OP_AFTER,  14'd2023,  4'd2,  5'd31, 3'd3, 1'b1, 14'd2023,  4'd3,  5'd1},
		// century years: not leap, then leap
		'{OP_LAST,   14'd1900,  4'd2,  5'd0,  3'd6, 1'b0, 14'd0,     4'd0,  5'd0},
		'{OP_LAST,   14'd2000,  4'd2,  5'd0,  3'd2, 1'b0, 14'd0,     4'd0,  5'd0},
		'{OP_LAST,   14'd9999,  4'd12, 5'd31, 3'd6, 1'b0, 14'd0,     4'd0,  5'd0},
		'{OP_LAST,   14'd1,     4'd1,  5'd1,  3'd0, 1'b0, 14'd0,     4'd0,  5'd0},
		'{OP_AFTER,  14'd1,     4'd1,  5'd1,  3'd6, 1'b0, 14'd0,     4'd0,  5'd0},
		'{OP_BEFORE, 14'd1,     4'd1,  5'd1,  3'd1, 1'b0, 14'd0,     4'd0,  5'd0},
		'{OP_AFTER,  14'd2019,  4'd1,  5'd31, 3'd7, 1'b0, 14'd0,     4'd0,  5'd0},
		// all field bits high
		'{OP_UNUSED, 14'd16383, 4'd15, 5'd31, 3'd7, 1'b0, 14'd0,     4'd0,  5'd0}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [OP_W-1:0]    op = '0;
	logic [YEAR_W-1:0]  year = '0;
	logic [MONTH_W-1:0] month = '0;
	logic [DAY_W-1:0]   day = '0;
	logic [WDAY_W-1:0]  weekday = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [YEAR_W-1:0]  result_year;
	logic [MONTH_W-1:0] result_month;
	logic [DAY_W-1:0]   resolved_day;

	rule_date_t  expected_dates [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	bit          idle_on = 1'b1;
	bit          long_hold_req = 1'b0;

	weekday_rule_day_resolver i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.year         (year),
		.month        (month),
		.day          (day),
		.weekday      (weekday),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_year  (result_year),
		.result_month (result_month),
		.resolved_day (resolved_day)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---- calendar predictor ------------------------------------------------

	function automatic int unsigned month_length(int unsigned y, int unsigned m);
		bit leap;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		case (m)
			2:           return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	// Day of week from the Julian day number, 0 Sunday.
	function automatic int unsigned day_of_week(int unsigned y, int unsigned m,
		int unsigned d);
		int unsigned early, shifted_y, shifted_m, jdn;
		early     = (14 - m) / 12;
		shifted_y = y + 4800 - early;
		shifted_m = m + 12 * early - 3;
		jdn = d + (153 * shifted_m + 2) / 5 + 365 * shifted_y + shifted_y / 4
			- shifted_y / 100 + shifted_y / 400 - 32045;
		return (jdn + 1) % 7;
	endfunction

	function automatic rule_date_t resolve_rule(logic [OP_W-1:0] rop,
		logic [YEAR_W-1:0] ryear, logic [MONTH_W-1:0] rmonth,
		logic [DAY_W-1:0] rday, logic [WDAY_W-1:0] rweekday);
		int unsigned y, m, d, w, span, cur, gap, r;
		int unsigned year_span;
		rule_date_t  res;
		year_span = 1 << YEAR_W;
		y = ryear;
		m = rmonth;
		d = rday;
		w = rweekday;
		cur = 0;
		// clamp month and weekday, then the day for the day-relative modes
		if (m < 1) m = 1;
		if (m > 12) m = 12;
		if (w > 6) w = 0;
		span = month_length(y, m);
		if (rop == OP_AFTER || rop == OP_BEFORE) begin
			if (d < 1) d = 1;
			if (d > span) d = span;
			cur = day_of_week(y, m, d);
		end
		if (rop == OP_AFTER) begin
			gap = (w + 7 - cur) % 7;
			r = d + gap;
			// spill over the end: take off the reference month's length
			if (r > span) begin
				r = r - span;
				m = m + 1;
				if (m > 12) begin
					m = 1;
					y = (y + 1) % year_span;
				end
			end
		end else if (rop == OP_BEFORE) begin
			gap = (cur + 7 - w) % 7;
			// borrow whenever the distance reaches day zero or below
			if (d <= gap) begin
				m = m - 1;
				if (m < 1) begin
					m = 12;
					y = (y + year_span - 1) % year_span;
				end
				r = d + month_length(y, m) - gap;
			end else begin
				r = d - gap;
			end
		end else begin
			cur = day_of_week(y, m, span);
			gap = (cur + 7 - w) % 7;
			r = span - gap;
		end
		res.year  = YEAR_W'(y);
		res.month = MONTH_W'(m);
		res.day   = DAY_W'(r);
		return res;
	endfunction

	// ---- request side ------------------------------------------------------

	// Offer one request, hold it until taken, then log its expected date.
	task automatic send_request(input rule_row_t req);
		rule_date_t want;
		// drop valid for a random burst now and then
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		op       <= req.op;
		year     <= req.year;
		month    <= req.month;
		day      <= req.day;
		weekday  <= req.weekday;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		if (req.typed) begin
			want.year  = req.exp_year;
			want.month = req.exp_month;
			want.day   = req.exp_day;
		end else begin
			want = resolve_rule(req.op, req.year, req.month, req.day, req.weekday);
		end
		expected_dates.push_back(want);
	endtask

	// Mostly well-formed dates, biased toward month and year ends; one in ten
	// requests is raw noise across the full field widths.
	function automatic rule_row_t random_request();
		rule_row_t req;
		req = '0;
		if ($urandom_range(0, 9) == 0) begin
			req.op      = OP_W'($urandom);
			req.year    = YEAR_W'($urandom);
			req.month   = MONTH_W'($urandom);
			req.day     = DAY_W'($urandom);
			req.weekday = WDAY_W'($urandom);
		end else begin
			req.op = OP_W'($urandom_range(0, 2));
			case ($urandom_range(0, 19))
				0:       req.year = YEAR_W'($urandom_range(0, 2));
				1:       req.year = YEAR_W'($urandom_range(16381, 16383));
				2:       req.year = YEAR_W'($urandom_range(10000, 16383));
				default: req.year = YEAR_W'($urandom_range(1, 9999));
			endcase
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 2))
					0:       req.month = 4'd1;
					1:       req.month = 4'd2;
					default: req.month = 4'd12;
				endcase
			end else begin
				req.month = MONTH_W'($urandom_range(1, 12));
			end
			if ($urandom_range(0, 2) == 0)
				req.day = ($urandom_range(0, 1) == 0) ? 5'd1 : DAY_W'($urandom_range(28, 31));
			else
				req.day = DAY_W'($urandom_range(1, 31));
			req.weekday = WDAY_W'($urandom_range(0, 6));
		end
		return req;
	endfunction

	// ---- result side -------------------------------------------------------

	// Hold off the result side in random bursts; a long hold on request
	// backs the pipeline up into in_stall while requests keep coming.
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Check each taken result against the oldest expected date.
	always @(posedge clk) begin
		rule_date_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_dates.size() == 0) begin
				$error("unexpected result: year %0d month %0d day %0d",
					result_year, result_month, resolved_day);
				mismatch_count++;
			end else begin
				want = expected_dates.pop_front();
				if (result_year !== want.year) begin
					$error("result_year: expected %0d, actual %0d", want.year, result_year);
					mismatch_count++;
				end
				if (result_month !== want.month) begin
					$error("result_month: expected %0d, actual %0d", want.month,
						result_month);
					mismatch_count++;
				end
				if (resolved_day !== want.day) begin
					$error("resolved_day: expected %0d, actual %0d", want.day,
						resolved_day);
					mismatch_count++;
				end
			end
		end
	end

	// Give up on a hang.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("weekday_rule_day_resolver_test failed");
			$finish;
		end
	end

	// ---- main sequence -----------------------------------------------------

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table first
		for (int i = 0; i < ROW_COUNT; i++)
			send_request(RULE_ROWS[i]);

		// random requests; back the pipeline up at the start and midway
		long_hold_req = 1'b1;
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			if (i == RANDOM_COUNT / 2)
				long_hold_req = 1'b1;
			// stream the tail with no gaps on either side
			if (i == RANDOM_COUNT - STREAM_COUNT)
				idle_on = 1'b0;
			send_request(random_request());
		end
		in_valid <= 1'b0;

		// drain, then give the pipeline a few more cycles
		while (expected_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("weekday_rule_day_resolver_test passed");
		else
			$display("weekday_rule_day_resolver_test failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/wrdr_pkg.sv
hw/rtl/wrdr_decode.sv
hw/rtl/wrdr_calendar.sv
hw/rtl/wrdr_resolve.sv
hw/rtl/weekday_rule_day_resolver.sv
hw/rtl/wrdr_checker.sv
test/weekday_rule_day_resolver_test.sv
